// File: hdl/srfp_pkg.sv
// Shared types and constants for the servo response frame parser.
// No dependencies; used by srfp_parse and servo_response_frame_parser.
package srfp_pkg;

  localparam int MAX_PARAMS   = 4;
  localparam int BODY_DEPTH   = MAX_PARAMS + 2;
  localparam int POS_W        = $clog2(BODY_DEPTH + 1);
  localparam int IDX_W        = 2;
  localparam int CNT_W        = 3;
  localparam logic [7:0] HDR_BYTE     = 8'h55;
  localparam logic [7:0] LEN_OVERHEAD = 8'd3;
  localparam logic [7:0] LEN_MAX      = LEN_OVERHEAD + 8'(MAX_PARAMS);

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN   = 3'd3,
    PH_BODY  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0]                  id;
    logic [7:0]                  cmd;
    logic [CNT_W-1:0]            count;
    logic [MAX_PARAMS-1:0][7:0]  params;
  } frame_t;

  typedef struct packed {
    logic final_pending;
    logic frame_ok;
  } parse_status_t;

endpackage

// File: hdl/srfp_parse.sv
// Byte-level frame parser: header hunt, length check, body capture, checksum.
// Depends on srfp_pkg.
module srfp_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   byte_valid,
  input  logic [7:0]             byte_data,
  output srfp_pkg::parse_status_t status,
  output srfp_pkg::frame_t       frame
);

  srfp_pkg::phase_t                phase_r, phase_nxt;
  logic [7:0]                      id_r, id_nxt;
  logic [srfp_pkg::POS_W-1:0]      len_r, len_nxt;
  logic [srfp_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [7:0]                      sum_r, sum_nxt;
  logic [7:0]                      store_r [srfp_pkg::BODY_DEPTH];
  logic [srfp_pkg::POS_W-1:0]      need;
  logic [srfp_pkg::POS_W-1:0]      pos_inc;
  logic                            in_range;
  logic                            store_we;
  logic                            frame_ok;

  assign need     = len_r - srfp_pkg::POS_W'(1);
  assign pos_inc  = pos_r + srfp_pkg::POS_W'(1);
  assign in_range = (phase_r == srfp_pkg::PH_BODY) &&
                    (pos_r < srfp_pkg::POS_W'(srfp_pkg::BODY_DEPTH)) && (pos_r < need);

  assign status.final_pending = in_range && (pos_inc == need);
  assign status.frame_ok      = frame_ok;

  always_comb begin
    phase_nxt = phase_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    store_we  = 1'b0;
    frame_ok  = 1'b0;
    if (byte_valid) begin
      case (phase_r)
        srfp_pkg::PH_HUNT1: begin
          if (byte_data == srfp_pkg::HDR_BYTE) phase_nxt = srfp_pkg::PH_HUNT2;
        end
        srfp_pkg::PH_HUNT2: begin
          phase_nxt = (byte_data == srfp_pkg::HDR_BYTE) ? srfp_pkg::PH_ID
                                                        : srfp_pkg::PH_HUNT1;
        end
        srfp_pkg::PH_ID: begin
          id_nxt    = byte_data;
          sum_nxt   = byte_data;
          phase_nxt = srfp_pkg::PH_LEN;
        end
        srfp_pkg::PH_LEN: begin
          if (byte_data < srfp_pkg::LEN_OVERHEAD || byte_data > srfp_pkg::LEN_MAX) begin
            phase_nxt = srfp_pkg::PH_HUNT1;
          end else begin
            len_nxt   = byte_data[srfp_pkg::POS_W-1:0];
            sum_nxt   = sum_r + byte_data;
            pos_nxt   = '0;
            phase_nxt = srfp_pkg::PH_BODY;
          end
        end
        srfp_pkg::PH_BODY: begin
          if (!in_range) begin
            phase_nxt = srfp_pkg::PH_HUNT1;
          end else begin
            store_we = 1'b1;
            pos_nxt  = pos_inc;
            if (pos_inc < need) begin
              sum_nxt = sum_r + byte_data;
            end else begin
              phase_nxt = srfp_pkg::PH_HUNT1;
              frame_ok  = (~sum_r == byte_data);
            end
          end
        end
        default: begin
          phase_nxt = srfp_pkg::PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= srfp_pkg::PH_HUNT1;
      id_r    <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      sum_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) store_r[pos_r[$clog2(srfp_pkg::BODY_DEPTH)-1:0]] <= byte_data;
  end

  always_comb begin
    frame.id    = id_r;
    frame.cmd   = store_r[0];
    frame.count = srfp_pkg::CNT_W'(len_r - srfp_pkg::POS_W'(srfp_pkg::LEN_OVERHEAD));
    for (int i = 0; i < srfp_pkg::MAX_PARAMS; i++) begin
      frame.params[i] = store_r[i+1];
    end
  end

endmodule

// File: hdl/servo_response_frame_parser.sv
// Latency: one byte per cycle in; the first result appears the cycle after the checksum
// transfer, then one result per cycle from the result buffer while out_tready is high.
// Throughput: one byte per cycle; input stalls only on a frame's checksum byte
// while the previous frame's results are still being drained.
// Reset: rst_n synchronous, active low; returns to the header hunt, empties output.
// Depends on srfp_pkg and srfp_parse.
module servo_response_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // resp_id[7:0], command[15:8], param_count[18:16],
                                  // param_index[20:19], param_byte[28:21], zeros[31:29]
  output logic        out_tlast   // last
);

  srfp_pkg::parse_status_t      status;
  srfp_pkg::frame_t             frame;
  srfp_pkg::frame_t             emit_r;
  logic                         busy_r, busy_nxt;
  logic [srfp_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic                         in_xfer;
  logic                         out_xfer;
  logic                         last;
  logic [7:0]                   pbyte;

  assign in_tready = !(busy_r && status.final_pending);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;

  srfp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_xfer),
    .byte_data  (in_tdata),
    .status     (status),
    .frame      (frame)
  );

  assign last  = (emit_r.count == '0) ||
                 ({1'b0, idx_r} == emit_r.count - srfp_pkg::CNT_W'(1));
  assign pbyte = (emit_r.count == '0) ? 8'h00 : emit_r.params[idx_r];

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (out_xfer) begin
      if (last) busy_nxt = 1'b0;
      else idx_nxt = idx_r + srfp_pkg::IDX_W'(1);
    end
    if (status.frame_ok) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (status.frame_ok) emit_r <= frame;
  end

  assign out_tvalid = busy_r;
  assign out_tlast  = last;
  assign out_tdata  = {3'b000, pbyte, idx_r, emit_r.count, emit_r.cmd, emit_r.id};

endmodule
